/* hw/rtl/rmca_pkg.sv */
// ----------------------------------------------------------------------------
// rmca_pkg
// Types, widths and modular bit-step helpers shared by the coefficient ALU.
// ----------------------------------------------------------------------------
package rmca_pkg;

  localparam int unsigned OP_W   = 64;
  localparam int unsigned MOD_W  = 60;
  localparam int unsigned MOD_REGS = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [MOD_W-1:0] MOD_RESET = 60'd12289;

  typedef enum logic [1:0] {
    ACT_MULADD = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_SUB    = 2'd2,
    ACT_MUL    = 2'd3
  } action_t;

  // Operand reduction stage: operands shift out one bit per stage.
  typedef struct packed {
    action_t         act;
    logic [1:0]      limb;
    logic [OP_W-1:0] oa;
    logic [OP_W-1:0] ob;
    logic [OP_W-1:0] oc;
    logic [MOD_W-1:0] ra;
    logic [MOD_W-1:0] rb;
    logic [MOD_W-1:0] rc;
  } red_t;

  // Multiply stage: b shifts out its top bit, acc doubles and adds.
  typedef struct packed {
    action_t          act;
    logic [1:0]       limb;
    logic [MOD_W-1:0] a;
    logic [MOD_W-1:0] b;
    logic [MOD_W-1:0] c;
    logic [MOD_W-1:0] acc;
  } mul_t;

  // (x + y) mod m for x, y < m.
  function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] x,
                                               input logic [MOD_W-1:0] y,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    logic [MOD_W:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    add_mod = (s >= {1'b0, m}) ? d[MOD_W-1:0] : s[MOD_W-1:0];
  endfunction

  // One restoring step of a remainder: (2r + bit) mod m for r < m.
  function automatic logic [MOD_W-1:0] red_bit(input logic [MOD_W-1:0] r,
                                               input logic bit_in,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] t;
    logic [MOD_W:0] d;
    t = {r, bit_in};
    d = t - {1'b0, m};
    red_bit = (t >= {1'b0, m}) ? d[MOD_W-1:0] : t[MOD_W-1:0];
  endfunction

  // One shift-and-add step of a modular product.
  function automatic logic [MOD_W-1:0] dbl_add(input logic [MOD_W-1:0] acc,
                                               input logic [MOD_W-1:0] x,
                                               input logic bit_in,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] d;
    d = add_mod(acc, acc, m);
    dbl_add = bit_in ? add_mod(d, x, m) : d;
  endfunction

endpackage

/* hw/rtl/rns_modular_coeff_alu.sv */
// An accepted input word passes 64 operand reduction stages, 60 multiply
// stages and one output stage on its way to its result word.
// Throughput: one word per cycle; each stage does one bit step of the
// reduction or of the shift-and-add product. A stall holds the whole pipe.
// Reset (rst_n, synchronous): pipeline emptied, moduli return to 12289.
// ----------------------------------------------------------------------------
// rns_modular_coeff_alu
// Pipelined modular multiply-add, add, subtract and multiply per RNS limb.
// ----------------------------------------------------------------------------
module rns_modular_coeff_alu #(
  parameter int unsigned NUM_LIMBS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [3:0]                       in_tuser,   // action[1:0], limb[3:2]
  input  logic [3*rmca_pkg::OP_W-1:0]      in_tdata,   // operand_a, operand_b, operand_c
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [63:0]                      out_tdata,  // result[59:0], zero pad
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rmca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmca_pkg::MOD_W-1:0]       cfg_data
);
  import rmca_pkg::*;

  localparam int unsigned RED_N = OP_W;
  localparam int unsigned MUL_N = MOD_W;

  logic [MOD_W-1:0] mod_r [MOD_REGS];
  logic             en;

  red_t red_q   [RED_N];
  logic red_v_r [RED_N];
  mul_t mul_q   [MUL_N];
  logic mul_v_r [MUL_N];

  logic             out_valid_r;
  logic [MOD_W-1:0] out_data_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(64-MOD_W){1'b0}}, out_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOD_REGS; i++) mod_r[i] <= MOD_RESET;
    end else if (cfg_valid && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(MOD_REGS))) begin
      mod_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  genvar k;
  generate
    for (k = 0; k < RED_N; k++) begin : g_red
      red_t src;
      logic src_v;
      red_t red_nxt;
      logic [MOD_W-1:0] m;
      if (k == 0) begin : g_first
        always_comb begin
          src.act  = action_t'(in_tuser[1:0]);
          src.limb = in_tuser[3:2];
          src.oa   = in_tdata[OP_W-1:0];
          src.ob   = in_tdata[2*OP_W-1:OP_W];
          src.oc   = in_tdata[3*OP_W-1:2*OP_W];
          src.ra   = '0;
          src.rb   = '0;
          src.rc   = '0;
          src_v    = in_tvalid;
        end
      end else begin : g_next
        assign src   = red_q[k-1];
        assign src_v = red_v_r[k-1];
      end
      assign m = mod_r[src.limb];
      always_comb begin
        red_nxt    = src;
        red_nxt.ra = red_bit(src.ra, src.oa[OP_W-1], m);
        red_nxt.rb = red_bit(src.rb, src.ob[OP_W-1], m);
        red_nxt.rc = red_bit(src.rc, src.oc[OP_W-1], m);
        red_nxt.oa = {src.oa[OP_W-2:0], 1'b0};
        red_nxt.ob = {src.ob[OP_W-2:0], 1'b0};
        red_nxt.oc = {src.oc[OP_W-2:0], 1'b0};
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          red_v_r[k] <= 1'b0;
        end else if (en) begin
          red_v_r[k] <= src_v;
        end
      end
      always_ff @(posedge clk) begin
        if (en) red_q[k] <= red_nxt;
      end
    end

    for (k = 0; k < MUL_N; k++) begin : g_mul
      mul_t src;
      logic src_v;
      mul_t mul_nxt;
      logic [MOD_W-1:0] m;
      if (k == 0) begin : g_first
        always_comb begin
          src.act  = red_q[RED_N-1].act;
          src.limb = red_q[RED_N-1].limb;
          src.a    = red_q[RED_N-1].ra;
          src.b    = red_q[RED_N-1].rb;
          src.c    = red_q[RED_N-1].rc;
          src.acc  = '0;
          src_v    = red_v_r[RED_N-1];
        end
      end else begin : g_next
        assign src   = mul_q[k-1];
        assign src_v = mul_v_r[k-1];
      end
      assign m = mod_r[src.limb];
      always_comb begin
        mul_nxt     = src;
        mul_nxt.acc = dbl_add(src.acc, src.a, src.b[MOD_W-1], m);
        mul_nxt.b   = {src.b[MOD_W-2:0], 1'b0};
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          mul_v_r[k] <= 1'b0;
        end else if (en) begin
          mul_v_r[k] <= src_v;
        end
      end
      always_ff @(posedge clk) begin
        if (en) mul_q[k] <= mul_nxt;
      end
    end
  endgenerate

  // The multiply stages keep a intact and shift b away, so the reduced b
  // rides along in its own delay line, loaded from the last reduction stage.
  mul_t             fin;
  logic [MOD_W-1:0] fin_m;
  logic [MOD_W-1:0] fin_b_r [MUL_N];
  logic [MOD_W-1:0] res_nxt;
  logic             zero_res;

  always_ff @(posedge clk) begin
    if (en) begin
      fin_b_r[0] <= red_q[RED_N-1].rb;
      for (int i = 1; i < MUL_N; i++) fin_b_r[i] <= fin_b_r[i-1];
    end
  end

  assign fin      = mul_q[MUL_N-1];
  assign fin_m    = mod_r[fin.limb];
  assign zero_res = (32'(fin.limb) >= NUM_LIMBS) || (fin_m == '0);

  always_comb begin
    case (fin.act)
      ACT_MULADD: res_nxt = add_mod(fin.acc, fin.c, fin_m);
      ACT_ADD:    res_nxt = add_mod(fin.a, fin_b_r[MUL_N-1], fin_m);
      ACT_SUB:    res_nxt = (fin.a >= fin_b_r[MUL_N-1]) ? (fin.a - fin_b_r[MUL_N-1])
                                                    : (fin.a - fin_b_r[MUL_N-1] + fin_m);
      ACT_MUL:    res_nxt = fin.acc;
      default:    res_nxt = '0;
    endcase
    if (zero_res) res_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mul_v_r[MUL_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= res_nxt;
  end

  // A stalled result word must stay put and keep its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The pad bits above the result are always zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:MOD_W] == '0)
    else $error("result pad bits set");

  // The input side is only held back by a stalled result word.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for rns_modular_coeff_alu
// Streams coefficient words through all four actions and limbs under several
// sets of moduli, including the widest, the smallest, one and zero. Every
// result word is compared with a prediction made from 128-bit arithmetic.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmca_pkg::*;

  localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};

  // Keeps the moduli as written and the results still owed by the block.
  class coeff_scoreboard;
    logic [MOD_W-1:0] moduli[MOD_REGS];
    logic [MOD_W-1:0] pending[$];
    int errors;
    int checked;

    function new();
      foreach (moduli[i]) moduli[i] = MOD_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void write_modulus(int idx, logic [MOD_W-1:0] val);
      if (idx < MOD_REGS) moduli[idx] = val;
    endfunction

    function void note_input(action_t act, logic [1:0] limb,
                             logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] m, ra, rb, rc, r;
      m = {68'd0, moduli[limb]};
      r = '0;
      if (m != 0) begin
        ra = {64'd0, a} % m;
        rb = {64'd0, b} % m;
        rc = {64'd0, c} % m;
        case (act)
          ACT_MULADD: r = (ra * rb + rc) % m;
          ACT_ADD:    r = (ra + rb) % m;
          ACT_SUB:    r = (ra + m - rb) % m;
          default:    r = (ra * rb) % m;
        endcase
      end
      pending = {pending, r[MOD_W-1:0]};
    endfunction

    function void check_result(logic [63:0] word);
      logic [MOD_W-1:0] want;
      checked++;
      if (pending.size() == 0) begin
        $error("result: no result expected, got %0d", word[MOD_W-1:0]);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (word[MOD_W-1:0] !== want) begin
        $error("result: expected %0d, got %0d", want, word[MOD_W-1:0]);
        errors++;
      end
      if (word[63:MOD_W] !== '0) begin
        $error("pad: expected 0, got %0d", word[63:MOD_W]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [3:0] in_tuser = '0;
  logic [3*OP_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MOD_W-1:0] cfg_data = '0;

  coeff_scoreboard sb = new();
  int words_sent = 0;

  always #5 clk = ~clk;

  rns_modular_coeff_alu i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Result side: a random stall before each word is taken.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_word(action_t act, logic [1:0] limb,
                           logic [63:0] a, logic [63:0] b, logic [63:0] c,
                           int gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = {limb, act};
    in_tdata = {c, b, a};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, limb, a, b, c);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int gap);
    logic [63:0] ops[3];
    logic [1:0] limb;
    limb = 2'($urandom_range(0, 3));
    foreach (ops[i]) begin
      case ($urandom_range(0, 5))
        0: ops[i] = '1;
        1: ops[i] = 64'($urandom_range(0, 3));
        2: ops[i] = {4'd0, sb.moduli[limb]} - 64'($urandom_range(0, 2));
        default: ops[i] = {$urandom, $urandom};
      endcase
    end
    send_word(action_t'($urandom_range(0, 3)), limb, ops[0], ops[1], ops[2], gap);
  endtask

  // Lets the pipe run dry before a register write.
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [MOD_W-1:0] val);
    cfg_index = idx[CFG_IDX_W-1:0];
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_modulus(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [MOD_W-1:0] random_modulus();
    logic [MOD_W-1:0] v;
    int w;
    w = $urandom_range(2, 60);
    v = MOD_W'({$urandom, $urandom});
    v = v & (MOD_MAX >> (60 - w));
    v[w-1] = 1'b1;
    if ($urandom_range(0, 9) == 0) v = MOD_MAX - MOD_W'($urandom_range(0, 100));
    return v;
  endfunction

  initial begin
    int gap;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset moduli first, then the extremes: widest, two, one and zero.
    for (int l = 0; l < 4; l++) send_word(ACT_MULADD, 2'(l), '1, '1, '1, 0);
    drain();
    write_reg(0, MOD_MAX);
    write_reg(1, 60'd2);
    write_reg(2, 60'd1);
    write_reg(3, 60'd0);
    // Indexes past the last register must leave the moduli untouched.
    for (int i = MOD_REGS; i < 8; i++) write_reg(i, 60'd7);
    for (int act = 0; act < 4; act++)
      for (int l = 0; l < 4; l++)
        send_word(action_t'(act), 2'(l), '1, 64'hFFFF_FFFF_FFFF_FFFE, '1, act % 2);
    send_word(ACT_SUB, 2'd0, 64'd0, '1, 64'd0, 0);
    send_word(ACT_MULADD, 2'd0, 64'd0, 64'd0, 64'd0, 0);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      for (int i = 0; i < 4; i++)
        write_reg(i, (phase == 4) ? MOD_MAX - MOD_W'(i) : random_modulus());
      for (int n = 0; n < 226; n++) begin
        gap = $urandom_range(0, 8);
        if (n < 40 && phase == 1) gap = 0;
        send_random(gap);
        if (n == 113 && phase == 2) begin
          // Hold the sender until the pipe has handed back everything.
          in_tvalid = 1'b0;
          while (sb.pending.size() != 0) @(negedge clk);
        end
      end
    end

    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (130) @(negedge clk);
    $display("Sent %0d coefficient words over seven sets of moduli; %0d results checked.",
             words_sent, sb.checked);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Timed out waiting for the block.");
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* rns_modular_coeff_alu.f */
hw/rtl/rmca_pkg.sv
hw/rtl/rns_modular_coeff_alu.sv
tb/sv/tb.sv
